// File: rtl/spbdt_pkg.sv
// ----------------------------------------------------------------------------
// spbdt_pkg - shared types and helpers for the sprite pixel raster op
// Payload structs, register indexes and the round-to-nearest /255 helper.
// ----------------------------------------------------------------------------
package spbdt_pkg;

    typedef struct packed {
        logic [31:0] source_pixel;
        logic [31:0] dest_pixel;
        logic [7:0]  stored_depth;
    } t_pix_in;

    typedef struct packed {
        logic        write_enable;
        logic [31:0] result_pixel;
    } t_pix_out;

    // per-beat mode bits carried down the pipe
    typedef struct packed {
        logic honour;
        logic tint;
    } t_mode;

    localparam int unsigned NUM_CHAN = 3;
    localparam int unsigned ADDR_W   = 5;

    localparam logic [2:0] REG_HONOUR_ALPHA = 3'd0;
    localparam logic [2:0] REG_DEPTH_EN     = 3'd1;
    localparam logic [2:0] REG_DEPTH_REF    = 3'd2;
    localparam logic [2:0] REG_TINT_EN      = 3'd3;
    localparam logic [2:0] REG_TINT_COLOR   = 3'd4;
    localparam logic [2:0] REG_ADDED_COLOR  = 3'd5;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;
    localparam logic [8:0]  ALPHA_ONE    = 9'h100;
    localparam logic [31:0] TINT_RESET   = 32'hFFFF_FFFF;

    // round(x / 255) for x <= 255*255: (x + 127) / 255 by reciprocal trick
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] y;
        logic [16:0] s;
        y = {1'b0, x} + 17'd127;
        s = y + {8'd0, y[16:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

// File: rtl/sprite_pixel_blend_depth_test.sv
// ----------------------------------------------------------------------------
// sprite_pixel_blend_depth_test - sprite pixel raster operation
// Alpha skip, depth test, untinted source-over blend and tint/add path.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive i_in (source, destination, stored depth) and raise
//   start. A beat is taken at each rising edge with start high and busy low.
//   busy is tied low, so one pixel can be taken every clock.
//   Output channel: o_result_valid pulses for one cycle with o_out holding
//   the write enable and the pixel to store. The receiver cannot stall; the
//   pipe never holds results back.
//   The result passes through four internal stages plus the output register
//   between the accepting edge and the edge that takes it. Throughput is
//   one pixel per clock; the multiply-add of stages B and D sets the period.
//   Configuration: APB, registers at 4*i, pready always high. Writes are
//   expected only while the pipe is empty.
//   Reset (synchronous, i_rst_n low) empties the pipe and loads the register
//   defaults: honour alpha 1, tint color all ones, the rest zero.
// Stages:
//   A: capture inputs, write decision (alpha skip, depth compare)
//   B: tint products, tint alpha product, untinted blend sums
//   C: /255 rounding, add and clamp, tinted alpha, untinted pixel
//   D: tinted blend products against the destination
//   E: /255 rounding of the blend, final select, output register
// ----------------------------------------------------------------------------
module sprite_pixel_blend_depth_test (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  spbdt_pkg::t_pix_in                   i_in,
    output logic                                 o_result_valid,
    output spbdt_pkg::t_pix_out                  o_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [spbdt_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    localparam int unsigned NC = spbdt_pkg::NUM_CHAN;

    // ---------------- configuration registers ----------------
    logic        r_honour_alpha;
    logic        r_depth_en;
    logic [7:0]  r_depth_ref;
    logic        r_tint_en;
    logic [31:0] r_tint_color;
    logic [31:0] r_added_color;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_honour_alpha <= 1'b1;
            r_depth_en     <= 1'b0;
            r_depth_ref    <= 8'd0;
            r_tint_en      <= 1'b0;
            r_tint_color   <= spbdt_pkg::TINT_RESET;
            r_added_color  <= 32'd0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                spbdt_pkg::REG_HONOUR_ALPHA: r_honour_alpha <= pwdata[0];
                spbdt_pkg::REG_DEPTH_EN:     r_depth_en     <= pwdata[0];
                spbdt_pkg::REG_DEPTH_REF:    r_depth_ref    <= pwdata[7:0];
                spbdt_pkg::REG_TINT_EN:      r_tint_en      <= pwdata[0];
                spbdt_pkg::REG_TINT_COLOR:   r_tint_color   <= pwdata;
                spbdt_pkg::REG_ADDED_COLOR:  r_added_color  <= pwdata;
                default: ;  // unmapped: ignored
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            spbdt_pkg::REG_HONOUR_ALPHA: prdata = {31'd0, r_honour_alpha};
            spbdt_pkg::REG_DEPTH_EN:     prdata = {31'd0, r_depth_en};
            spbdt_pkg::REG_DEPTH_REF:    prdata = {24'd0, r_depth_ref};
            spbdt_pkg::REG_TINT_EN:      prdata = {31'd0, r_tint_en};
            spbdt_pkg::REG_TINT_COLOR:   prdata = r_tint_color;
            spbdt_pkg::REG_ADDED_COLOR:  prdata = r_added_color;
            default:                     prdata = 32'd0;
        endcase
    end

    // ---------------- stage A: capture + write decision ----------------
    logic                r_a_vld, n_a_vld;
    logic                r_a_we,  n_a_we;
    spbdt_pkg::t_mode    r_a_mode, n_a_mode;
    logic [31:0]         r_a_src, r_a_dst;

    always_comb begin
        n_a_vld       = start & ~busy;
        n_a_mode.honour = r_honour_alpha;
        n_a_mode.tint   = r_tint_en;
        // alpha skip and depth test
        n_a_we = 1'b1;
        if (r_honour_alpha && i_in.source_pixel[31:24] == spbdt_pkg::ALPHA_CLEAR)
            n_a_we = 1'b0;
        if (r_depth_en && r_depth_ref < i_in.stored_depth)
            n_a_we = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= n_a_vld;
        end
        r_a_we   <= n_a_we;
        r_a_mode <= n_a_mode;
        r_a_src  <= i_in.source_pixel;
        r_a_dst  <= i_in.dest_pixel;
    end

    // ---------------- stage B: products ----------------
    logic                 r_b_vld;
    logic                 r_b_we;
    spbdt_pkg::t_mode     r_b_mode;
    logic [31:0]          r_b_src, r_b_dst;
    logic [NC-1:0][15:0]  r_b_tp,  n_b_tp;    // source * tint
    logic [15:0]          r_b_tap, n_b_tap;   // source alpha * tint alpha
    logic [NC-1:0][16:0]  r_b_us,  n_b_us;    // untinted blend sums
    logic [8:0]           inv_a;

    always_comb begin
        inv_a   = spbdt_pkg::ALPHA_ONE - {1'b0, r_a_src[31:24]};
        n_b_tap = r_a_src[31:24] * r_tint_color[31:24];
        for (int k = 0; k < NC; k++) begin
            n_b_tp[k] = r_a_src[8*k +: 8] * r_tint_color[8*k +: 8];
            n_b_us[k] = 17'(r_a_src[8*k +: 8] * r_a_src[31:24])
                      + 17'(r_a_dst[8*k +: 8] * inv_a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_we   <= r_a_we;
        r_b_mode <= r_a_mode;
        r_b_src  <= r_a_src;
        r_b_dst  <= r_a_dst;
        r_b_tp   <= n_b_tp;
        r_b_tap  <= n_b_tap;
        r_b_us   <= n_b_us;
    end

    // ---------------- stage C: round, add, clamp ----------------
    logic                 r_c_vld;
    logic                 r_c_we;
    spbdt_pkg::t_mode     r_c_mode;
    logic [31:0]          r_c_src, r_c_dst;
    logic [NC-1:0][7:0]   r_c_col, n_c_col;   // tinted color before blend
    logic [7:0]           r_c_alp, n_c_alp;   // tinted alpha
    logic [31:0]          r_c_upx, n_c_upx;   // untinted blended pixel
    logic [8:0]           sum_c;

    always_comb begin
        n_c_alp = r_b_mode.honour ? spbdt_pkg::div255(r_b_tap) : r_tint_color[31:24];
        n_c_upx[31:24] = spbdt_pkg::ALPHA_OPAQUE;
        sum_c = 9'd0;
        for (int k = 0; k < NC; k++) begin
            sum_c = {1'b0, r_added_color[8*k +: 8]}
                  + {1'b0, spbdt_pkg::div255(r_b_tp[k])};
            n_c_col[k] = sum_c[8] ? spbdt_pkg::ALPHA_OPAQUE : sum_c[7:0];
            n_c_upx[8*k +: 8] = r_b_us[k][15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
        r_c_we   <= r_b_we;
        r_c_mode <= r_b_mode;
        r_c_src  <= r_b_src;
        r_c_dst  <= r_b_dst;
        r_c_col  <= n_c_col;
        r_c_alp  <= n_c_alp;
        r_c_upx  <= n_c_upx;
    end

    // ---------------- stage D: tinted blend products ----------------
    logic                 r_d_vld;
    logic                 r_d_we;
    spbdt_pkg::t_mode     r_d_mode;
    logic [31:0]          r_d_src, r_d_dst, r_d_upx;
    logic [NC-1:0][7:0]   r_d_col;
    logic [7:0]           r_d_alp;
    logic [NC-1:0][15:0]  r_d_bp, n_d_bp;
    logic [7:0]           inv_c;

    always_comb begin
        inv_c = spbdt_pkg::ALPHA_OPAQUE - r_c_alp;
        for (int k = 0; k < NC; k++) begin
            // sum never exceeds 255*255, fits in 16 bits
            n_d_bp[k] = 16'(r_c_col[k] * r_c_alp) + 16'(r_c_dst[8*k +: 8] * inv_c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
        r_d_we   <= r_c_we;
        r_d_mode <= r_c_mode;
        r_d_src  <= r_c_src;
        r_d_dst  <= r_c_dst;
        r_d_upx  <= r_c_upx;
        r_d_col  <= r_c_col;
        r_d_alp  <= r_c_alp;
        r_d_bp   <= n_d_bp;
    end

    // ---------------- stage E: final select, output register ----------------
    logic                 r_e_vld;
    logic                 r_e_honour;
    spbdt_pkg::t_pix_out  r_e_out, n_e_out;
    logic [31:0]          tint_px;

    always_comb begin
        if (r_d_alp != spbdt_pkg::ALPHA_OPAQUE) begin
            tint_px[31:24] = spbdt_pkg::ALPHA_OPAQUE;
            for (int k = 0; k < NC; k++)
                tint_px[8*k +: 8] = spbdt_pkg::div255(r_d_bp[k]);
        end else begin
            tint_px[31:24] = r_d_alp;
            for (int k = 0; k < NC; k++)
                tint_px[8*k +: 8] = r_d_col[k];
        end

        n_e_out.write_enable = r_d_we;
        if (!r_d_we)
            n_e_out.result_pixel = r_d_dst;
        else if (r_d_mode.tint)
            n_e_out.result_pixel = tint_px;
        else if (r_d_mode.honour && r_d_src[31:24] != spbdt_pkg::ALPHA_OPAQUE)
            n_e_out.result_pixel = r_d_upx;
        else
            n_e_out.result_pixel = r_d_src;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= r_d_vld;
        end
        r_e_honour <= r_d_mode.honour;
        r_e_out    <= n_e_out;
    end

    assign o_result_valid = r_e_vld;
    assign o_out          = r_e_out;

    // ---------------- assertions ----------------
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_result_valid)
        else $error("result beat missing five cycles after accept");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && $past(i_rst_n, 5)) |-> $past(start, 5))
        else $error("result beat without a matching accept");

    a_skip_keeps_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_out.write_enable)
            |-> o_out.result_pixel == $past(i_in.dest_pixel, 5))
        else $error("skipped pixel does not return destination");

    a_written_not_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_out.write_enable && r_e_honour)
            |-> o_out.result_pixel[31:24] != spbdt_pkg::ALPHA_CLEAR)
        else $error("written pixel with alpha honoured has zero alpha");

endmodule
